FILE: design/imu6_pkg.sv
// Shared types, constants and register indexes for the six-axis IMU conditioning block.
// Used by imu6_cfg, imu6_ctrl, imu6_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package imu6_pkg;

    // Output fixed-point format and scaler layout
    localparam int OUT_FRAC_BITS = 16;
    localparam int SCALE_FRAC    = 24;
    localparam int SCALE_SHIFT   = SCALE_FRAC - OUT_FRAC_BITS;
    localparam int WEIGHT_FRAC   = 16;

    localparam int NUM_AXES  = 6;
    localparam int AXIS_W    = 3;
    localparam int RAW_W     = 16;
    localparam int ACC_W     = 24;
    localparam int GYR_W     = 28;
    localparam int TIME_W    = 32;

    localparam int ACC_SCALE_W = 16;
    localparam int GYR_SCALE_W = 20;
    localparam int WEIGHT_W    = 17;
    localparam int IVL_W       = 8;

    // Shared multiplier: difference or raw sample (GYR_W+1) by weight or scale (GYR_SCALE_W+1)
    localparam int MUL_A_W = GYR_W + 1;
    localparam int MUL_B_W = GYR_SCALE_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = MUL_A_W + WEIGHT_W + 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC);

    // Axis order: accel x,y,z then gyro x,y,z
    localparam logic [AXIS_W-1:0] GYRO_BASE = AXIS_W'(3);

    // Sequencer: two multiplier passes per axis, plus one trailing update
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * NUM_AXES);

    // Stream widths
    localparam int S_TDATA_W = TIME_W + NUM_AXES * RAW_W;
    localparam int M_PAYLOAD_W = TIME_W + 3 * ACC_W + 3 * GYR_W;
    localparam int M_TDATA_W = ((M_PAYLOAD_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_INTERVAL  = 3'd6;

    localparam logic [ACC_SCALE_W-1:0] ACC_SCALE_RST = 16'd20073;
    localparam logic [GYR_SCALE_W-1:0] GYR_SCALE_RST = 20'd293601;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RST    = 17'd13107;
    localparam logic [IVL_W-1:0]       IVL_RST       = 8'd5;

    typedef struct packed {
        logic signed [RAW_W-1:0]  gyro_bias_x;
        logic signed [RAW_W-1:0]  gyro_bias_y;
        logic signed [RAW_W-1:0]  gyro_bias_z;
        logic [ACC_SCALE_W-1:0]   accel_scale;
        logic [GYR_SCALE_W-1:0]   gyro_scale;
        logic [WEIGHT_W-1:0]      smoothing_weight;
        logic [IVL_W-1:0]         emit_interval;
    } cfg_t;

    typedef struct packed {
        logic              capture;
        logic              mul_en;
        logic              mul_filt;
        logic [AXIS_W-1:0] mul_axis;
        logic              upd_en;
        logic [AXIS_W-1:0] upd_axis;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/imu6_cfg.sv
// Configuration register file for the IMU conditioning block.
// Depends on imu6_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module imu6_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [imu6_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [imu6_pkg::CFG_DATA_W-1:0]   cfg_data,
    output imu6_pkg::cfg_t                         cfg
);

    imu6_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gyro_bias_x      <= '0;
            cfg_reg.gyro_bias_y      <= '0;
            cfg_reg.gyro_bias_z      <= '0;
            cfg_reg.accel_scale      <= imu6_pkg::ACC_SCALE_RST;
            cfg_reg.gyro_scale       <= imu6_pkg::GYR_SCALE_RST;
            cfg_reg.smoothing_weight <= imu6_pkg::WEIGHT_RST;
            cfg_reg.emit_interval    <= imu6_pkg::IVL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                imu6_pkg::CFG_GYRO_BIAS_X: begin
                    cfg_reg.gyro_bias_x <= cfg_data[imu6_pkg::RAW_W-1:0];
                end
                imu6_pkg::CFG_GYRO_BIAS_Y: begin
                    cfg_reg.gyro_bias_y <= cfg_data[imu6_pkg::RAW_W-1:0];
                end
                imu6_pkg::CFG_GYRO_BIAS_Z: begin
                    cfg_reg.gyro_bias_z <= cfg_data[imu6_pkg::RAW_W-1:0];
                end
                imu6_pkg::CFG_ACCEL_SCALE: begin
                    cfg_reg.accel_scale <= cfg_data[imu6_pkg::ACC_SCALE_W-1:0];
                end
                imu6_pkg::CFG_GYRO_SCALE: begin
                    cfg_reg.gyro_scale <= cfg_data[imu6_pkg::GYR_SCALE_W-1:0];
                end
                imu6_pkg::CFG_SMOOTH_WEIGHT: begin
                    cfg_reg.smoothing_weight <= cfg_data[imu6_pkg::WEIGHT_W-1:0];
                end
                imu6_pkg::CFG_EMIT_INTERVAL: begin
                    cfg_reg.emit_interval <= cfg_data[imu6_pkg::IVL_W-1:0];
                end
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/imu6_ctrl.sv
// Sequencer for the IMU conditioning block: accepts a sample, steps the shared
// multiplier through scale and filter passes, then hands the result off when it is emitted.
// Depends on imu6_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module imu6_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire imu6_pkg::sts_t sts,
    output imu6_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [imu6_pkg::STEP_W-1:0]    step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == imu6_pkg::STEP_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result, unless this sample is not emitted
                if (!sts.emit || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Even steps scale axis step/2 (except the last step) and retire the filter of the axis
    // before it (except step 0); odd steps run the filter multiply of axis step/2.
    always_comb begin
        cmd.capture  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mul_en   = (state_reg == ST_RUN) && (step_reg != imu6_pkg::STEP_LAST);
        cmd.mul_filt = step_reg[0];
        cmd.mul_axis = step_reg[imu6_pkg::STEP_W-1:1];
        cmd.upd_en   = (state_reg == ST_RUN) && !step_reg[0]
                       && (step_reg[imu6_pkg::STEP_W-1:1] != '0);
        cmd.upd_axis = step_reg[imu6_pkg::STEP_W-1:1] - 1'b1;
        cmd.load_out = (state_reg == ST_DONE) && sts.emit && sts.out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

FILE: design/imu6_dp.sv
// Datapath of the IMU conditioning block: sample register with gyro bias removal,
// shared multiplier, filter state, decimation phase and the output register.
// Depends on imu6_pkg for widths, the config struct and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module imu6_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire imu6_pkg::cfg_t                    cfg,
    input  wire imu6_pkg::cmd_t                    cmd,
    output imu6_pkg::sts_t                         sts,
    input  wire logic [imu6_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [imu6_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int SAT_W = imu6_pkg::GYR_W + 12;
    localparam logic signed [SAT_W-1:0] ACC_MAX =
        (SAT_W'(1) <<< (imu6_pkg::ACC_W - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] GYR_MAX =
        (SAT_W'(1) <<< (imu6_pkg::GYR_W - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] ACC_MIN = -ACC_MAX - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] GYR_MIN = -GYR_MAX - SAT_W'(1);
    localparam int RW = imu6_pkg::RAW_W;
    localparam int TW = imu6_pkg::TIME_W;

    function automatic logic signed [imu6_pkg::GYR_W-1:0] sat_axis(
        input logic signed [SAT_W-1:0] v,
        input logic                    is_gyro
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        logic signed [SAT_W-1:0] r;
        hi = is_gyro ? GYR_MAX : ACC_MAX;
        lo = is_gyro ? GYR_MIN : ACC_MIN;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[imu6_pkg::GYR_W-1:0];
    endfunction

    function automatic logic signed [RW-1:0] unbias(
        input logic signed [RW-1:0] raw,
        input logic signed [RW-1:0] bias
    );
        logic signed [RW:0] d;
        d = (RW+1)'(raw) - (RW+1)'(bias);
        if (d[RW] != d[RW-1]) begin
            return d[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
        end
        return d[RW-1:0];
    endfunction

    logic signed [RW-1:0]               raw_reg [imu6_pkg::NUM_AXES];
    logic [TW-1:0]                      time_reg;
    logic signed [imu6_pkg::GYR_W-1:0]  y_reg [imu6_pkg::NUM_AXES];
    logic signed [imu6_pkg::GYR_W-1:0]  ysel_reg;
    logic signed [imu6_pkg::PROD_W-1:0] prod_reg;
    logic                               seeded_reg;
    logic                               first_reg;
    logic                               emit_reg;
    logic [imu6_pkg::IVL_W-1:0]         phase_reg, phase_next;
    logic                               m_tvalid_reg;
    logic [imu6_pkg::M_TDATA_W-1:0]     m_tdata_reg;

    logic signed [RW-1:0]                raw_sel;
    logic                                mul_is_gyro;
    logic signed [imu6_pkg::PROD_W-1:0]  scaled_full;
    logic signed [imu6_pkg::GYR_W-1:0]   x_val;
    logic signed [imu6_pkg::GYR_W-1:0]   y_cur;
    logic signed [imu6_pkg::MUL_A_W-1:0] diff;
    logic [imu6_pkg::WEIGHT_W-1:0]       wgt_eff;
    logic signed [imu6_pkg::MUL_A_W-1:0] mul_a;
    logic signed [imu6_pkg::MUL_B_W-1:0] mul_b;
    logic signed [imu6_pkg::MUL_P_W-1:0] mul_full;
    logic signed [imu6_pkg::PROD_W-1:0]  upd_full;
    logic signed [SAT_W-1:0]             upd_term;
    logic signed [SAT_W-1:0]             upd_sum;
    logic signed [imu6_pkg::GYR_W-1:0]   y_new;
    logic [imu6_pkg::IVL_W-1:0]          ivl;
    logic [imu6_pkg::IVL_W:0]            phase_inc;

    // Scale pass: raw x scale. Filter pass: (x - y) x weight.
    always_comb begin
        raw_sel     = raw_reg[cmd.mul_axis];
        mul_is_gyro = (cmd.mul_axis >= imu6_pkg::GYRO_BASE);
        scaled_full = prod_reg >>> imu6_pkg::SCALE_SHIFT;
        x_val       = sat_axis(scaled_full[SAT_W-1:0], mul_is_gyro);
        y_cur       = y_reg[cmd.mul_axis];
        diff        = imu6_pkg::MUL_A_W'(x_val) - imu6_pkg::MUL_A_W'(y_cur);
        // an unseeded filter takes full weight, so y becomes x exactly
        if (first_reg || (cfg.smoothing_weight > imu6_pkg::WEIGHT_ONE)) begin
            wgt_eff = imu6_pkg::WEIGHT_ONE;
        end else begin
            wgt_eff = cfg.smoothing_weight;
        end
        if (cmd.mul_filt) begin
            mul_a = diff;
            mul_b = imu6_pkg::MUL_B_W'(wgt_eff);
        end else begin
            mul_a = imu6_pkg::MUL_A_W'(raw_sel);
            mul_b = mul_is_gyro ? imu6_pkg::MUL_B_W'(cfg.gyro_scale)
                                : imu6_pkg::MUL_B_W'(cfg.accel_scale);
        end
        mul_full = mul_a * mul_b;

        upd_full = prod_reg >>> imu6_pkg::WEIGHT_FRAC;
        upd_term = upd_full[SAT_W-1:0];
        upd_sum  = SAT_W'(ysel_reg) + upd_term;
        y_new    = sat_axis(upd_sum, cmd.upd_axis >= imu6_pkg::GYRO_BASE);

        ivl        = (cfg.emit_interval == '0) ? imu6_pkg::IVL_W'(1) : cfg.emit_interval;
        phase_inc  = {1'b0, phase_reg} + 1'b1;
        phase_next = (phase_inc >= {1'b0, ivl}) ? '0 : phase_inc[imu6_pkg::IVL_W-1:0];
    end

    // Sample capture and multiplier pipeline
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            time_reg   <= s_tdata[TW-1:0];
            raw_reg[0] <= s_tdata[TW+4*RW-1 -: RW];
            raw_reg[1] <= s_tdata[TW+5*RW-1 -: RW];
            raw_reg[2] <= s_tdata[TW+6*RW-1 -: RW];
            raw_reg[3] <= unbias(s_tdata[TW+1*RW-1 -: RW], cfg.gyro_bias_x);
            raw_reg[4] <= unbias(s_tdata[TW+2*RW-1 -: RW], cfg.gyro_bias_y);
            raw_reg[5] <= unbias(s_tdata[TW+3*RW-1 -: RW], cfg.gyro_bias_z);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_full[imu6_pkg::PROD_W-1:0];
        end
        if (cmd.mul_en && cmd.mul_filt) begin
            ysel_reg <= y_cur;
        end
    end

    // Filter state, seeding and decimation phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < imu6_pkg::NUM_AXES; i++) begin
                y_reg[i] <= '0;
            end
            seeded_reg <= 1'b0;
            first_reg  <= 1'b0;
            emit_reg   <= 1'b0;
            phase_reg  <= '0;
        end else begin
            if (cmd.capture) begin
                first_reg  <= !seeded_reg;
                seeded_reg <= 1'b1;
                emit_reg   <= (phase_reg == '0);
                phase_reg  <= phase_next;
            end
            if (cmd.upd_en) begin
                y_reg[cmd.upd_axis] <= y_new;
            end
        end
    end

    // Output register: a waiting result does not block the next sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= imu6_pkg::M_TDATA_W'({
                y_reg[5],
                y_reg[4],
                y_reg[3],
                y_reg[2][imu6_pkg::ACC_W-1:0],
                y_reg[1][imu6_pkg::ACC_W-1:0],
                y_reg[0][imu6_pkg::ACC_W-1:0],
                time_reg
            });
        end
    end

    assign sts.emit     = emit_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule

`default_nettype wire

FILE: design/imu_six_axis_scale_lowpass_decimate.sv
// Six-axis IMU conditioning: gyro bias removal, scaling to Q16 physical units,
// first-order low-pass seeded by the first sample, and 1-in-N decimation. A sample
// is taken when s_tready is high and occupies the block for a capture, thirteen steps
// in which one shared multiplier makes two passes per axis (scale, then filter weight)
// over six axes with a trailing update, and a hand-off of an emitted result to the
// output register. A finished result waits in that register while the next sample
// is taken; the block stalls only if a second result is ready before the first is
// taken. Only the first sample and every emit_interval-th one after it produce a
// transaction on the m_ side. Registers are written through cfg_wr_en/cfg_index/
// cfg_data and should be changed only while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module imu_six_axis_scale_lowpass_decimate (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [imu6_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [imu6_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // time_ms[31:0], rate_x_raw[47:32], rate_y_raw[63:48], rate_z_raw[79:64],
    // acc_x_raw[95:80], acc_y_raw[111:96], acc_z_raw[127:112]
    input  wire logic [imu6_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // stamp_ms[31:0], acc_x_smooth[55:32], acc_y_smooth[79:56], acc_z_smooth[103:80],
    // rate_x_smooth[131:104], rate_y_smooth[159:132], rate_z_smooth[187:160], zero[191:188]
    output logic [imu6_pkg::M_TDATA_W-1:0]         m_tdata
);

    imu6_pkg::cfg_t cfg;
    imu6_pkg::cmd_t cmd;
    imu6_pkg::sts_t sts;

    imu6_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    imu6_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imu6_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
